[design/atp_pkg.sv]
// ----------------------------------------------------------------------------
// Angular trapezoid profile package
// Fixed-point constants, shared-unit request/response types and helpers.
// ----------------------------------------------------------------------------
package atp_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic signed [63:0] Q_ONE = 64'sd1 <<< FRAC_BITS;

    // Shared unit sizing
    localparam int DIV_STEPS   = 64;
    localparam int SQRT_STEPS  = (31 + FRAC_BITS + 1) / 2;
    localparam int SQRT_SHIFT  = FRAC_BITS + 64 - 2 * SQRT_STEPS;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int REM_W       = 34;

    // Shared unit operations
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_MAX_VEL   = 2'd0;
    localparam logic [1:0] REG_MAX_ACC   = 2'd1;
    localparam logic [1:0] REG_MIN_VEL   = 2'd2;
    localparam logic [1:0] REG_STEP_TIME = 2'd3;

    // Distance bands (quarters of a radian) and matching speed offsets
    localparam logic signed [31:0] DIST_BOUND [5] = '{
        32'sd15 <<< (FRAC_BITS - 2), 32'sd8 <<< (FRAC_BITS - 2),
        32'sd4 <<< (FRAC_BITS - 2),  32'sd2 <<< (FRAC_BITS - 2),
        32'sd1 <<< (FRAC_BITS - 2)};
    localparam logic signed [31:0] SPEED_OFFSET [6] = '{
        32'sd4 <<< (FRAC_BITS - 2),  32'sd6 <<< (FRAC_BITS - 2),
        32'sd8 <<< (FRAC_BITS - 2),  32'sd11 <<< (FRAC_BITS - 2),
        32'sd14 <<< (FRAC_BITS - 2), 32'sd16 <<< (FRAC_BITS - 2)};

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_rsp;

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Product rescale: truncate toward zero, then saturate
    function automatic logic signed [31:0] f_qscale(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (p[63] ? (Q_ONE - 64'sd1) : 64'sd0);
        return f_sat32(t >>> FRAC_BITS);
    endfunction

    // Halve, truncating toward zero
    function automatic logic signed [63:0] f_half(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + (v[63] ? 64'sd1 : 64'sd0);
        return t >>> 1;
    endfunction

    function automatic logic signed [31:0] f_offset(input logic signed [31:0] d);
        logic signed [31:0] off;
        off = SPEED_OFFSET[5];
        for (int i = 4; i >= 0; i--) begin
            if (d > DIST_BOUND[i]) begin
                off = SPEED_OFFSET[i];
            end
        end
        return off;
    endfunction

endpackage

[design/atp_alu.sv]
// ----------------------------------------------------------------------------
// Angular trapezoid profile shared arithmetic unit
// Multiplier, bit-serial signed divide, digit-serial square root.
// ----------------------------------------------------------------------------
module atp_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  atp_pkg::t_alu_req   i_req,
    input  logic signed [63:0]  i_op_a,
    input  logic signed [32:0]  i_op_b,
    output atp_pkg::t_alu_rsp   o_rsp,
    output logic signed [63:0]  o_result
);
    import atp_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_FIN  = 2'd2;

    logic [1:0]         r_phase;
    logic [1:0]         r_op;
    logic [CNT_W-1:0]   r_cnt;
    logic [63:0]        r_num;
    logic [32:0]        r_den;
    logic [REM_W-1:0]   r_rem;
    logic [63:0]        r_quo;
    logic               r_neg;
    logic               r_done;
    logic signed [63:0] r_res;

    logic signed [63:0] w_prod;
    logic [REM_W-1:0]   w_div_sh;
    logic               w_div_ge;
    logic [REM_W-1:0]   w_sq_sh;
    logic [REM_W-1:0]   w_sq_trial;
    logic               w_sq_ge;
    logic signed [63:0] w_fin;

    assign w_prod     = $signed(i_op_a[31:0]) * $signed(i_op_b[31:0]);
    assign w_div_sh   = {r_rem[REM_W-2:0], r_num[63]};
    assign w_div_ge   = w_div_sh >= REM_W'(r_den);
    assign w_sq_sh    = {r_rem[REM_W-3:0], r_num[63:62]};
    assign w_sq_trial = {r_quo[REM_W-3:0], 2'b01};
    assign w_sq_ge    = w_sq_sh >= w_sq_trial;

    // For a divide, saturate the quotient magnitude and restore its sign; a root result passes through
    always_comb begin
        if (r_op == OP_DIV) begin
            if (r_neg) begin
                w_fin = (r_quo > 64'h8000_0000) ? -64'sd2147483648 : -$signed(r_quo);
            end else begin
                w_fin = (r_quo > 64'h7fff_ffff) ? 64'sd2147483647 : $signed(r_quo);
            end
        end else begin
            w_fin = $signed(r_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_req.start) begin
                        r_op <= i_req.op;
                        r_rem <= '0;
                        r_quo <= '0;
                        if (i_req.op == OP_MUL) begin
                            r_res  <= w_prod;
                            r_done <= 1'b1;
                        end else if (i_req.op == OP_DIV) begin
                            r_num   <= i_op_a[63] ? 64'(-i_op_a) : 64'(i_op_a);
                            r_neg   <= i_op_a[63];
                            r_den   <= i_op_b;
                            r_cnt   <= CNT_W'(DIV_STEPS - 1);
                            r_phase <= PH_RUN;
                        end else begin
                            r_num   <= 64'(i_op_a[30:0]) << SQRT_SHIFT;
                            r_cnt   <= CNT_W'(SQRT_STEPS - 1);
                            r_phase <= PH_RUN;
                        end
                    end
                end
                PH_RUN: begin
                    if (r_op == OP_DIV) begin
                        r_rem <= w_div_ge ? (w_div_sh - REM_W'(r_den)) : w_div_sh;
                        r_quo <= {r_quo[62:0], w_div_ge};
                        r_num <= {r_num[62:0], 1'b0};
                    end else begin
                        r_rem <= w_sq_ge ? (w_sq_sh - w_sq_trial) : w_sq_sh;
                        r_quo <= {r_quo[62:0], w_sq_ge};
                        r_num <= {r_num[61:0], 2'b00};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_phase <= PH_FIN;
                    end
                end
                PH_FIN: begin
                    r_res   <= w_fin;
                    r_done  <= 1'b1;
                    r_phase <= PH_IDLE;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.busy = (r_phase != PH_IDLE);
    assign o_rsp.done = r_done;
    assign o_result   = r_res;

endmodule

[design/angular_trapezoid_profile_core.sv]
// ----------------------------------------------------------------------------
// Angular trapezoid profile core
// Trapezoidal turn-velocity profile generator in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage: write max velocity, max acceleration, min velocity and step time
// over the APB port while the core is idle. Send an input transfer with
// action 0 and the target angle to plan a turn; it yields no result. Each
// following transfer with action 1 yields one result transfer: angle
// travelled, velocity, acceleration and a last-point flag. Steps while no
// turn runs (finished, or a negative target) yield nothing.
// Sequencing: multiplies, divides and square roots all go through one
// shared unit: a multiplier, a 64-step bit-serial divider and a 24-step
// square root. A plan runs seven divides and seven multiplies. A step on
// the ramp up or ramp down runs its multiplies and a square root, which
// dominates; a cruise step runs one multiply. The input stall stays high
// while the sequencer works; one item is handled at a time.
// Output: the result sits in an output register; the next item is taken
// while it waits, and a further result holds the sequencer until the
// receiver drops its stall.
// Reset: synchronous, active low; control and configuration registers return
// to their defaults and no turn is active.
// ----------------------------------------------------------------------------
module angular_trapezoid_profile_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic signed [31:0] i_target_angle,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_angle_done,
    output logic signed [31:0] o_velocity,
    output logic signed [31:0] o_acceleration,
    output logic               o_last_point,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import atp_pkg::*;

    // Sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_DA    = 5'd1;
    localparam logic [4:0] ST_VV    = 5'd2;
    localparam logic [4:0] ST_BASE  = 5'd3;
    localparam logic [4:0] ST_PEAK  = 5'd4;
    localparam logic [4:0] ST_RISE  = 5'd5;
    localparam logic [4:0] ST_V0A   = 5'd6;
    localparam logic [4:0] ST_DAD   = 5'd7;
    localparam logic [4:0] ST_SQ1   = 5'd8;
    localparam logic [4:0] ST_SQ2   = 5'd9;
    localparam logic [4:0] ST_PKA   = 5'd10;
    localparam logic [4:0] ST_TIMES = 5'd11;
    localparam logic [4:0] ST_M1    = 5'd12;
    localparam logic [4:0] ST_M2    = 5'd13;
    localparam logic [4:0] ST_M3    = 5'd14;
    localparam logic [4:0] ST_M4    = 5'd15;
    localparam logic [4:0] ST_M5    = 5'd16;
    localparam logic [4:0] ST_U1    = 5'd17;
    localparam logic [4:0] ST_U2    = 5'd18;
    localparam logic [4:0] ST_D1    = 5'd19;
    localparam logic [4:0] ST_D2    = 5'd20;
    localparam logic [4:0] ST_D3    = 5'd21;
    localparam logic [4:0] ST_ROOT  = 5'd22;
    localparam logic [4:0] ST_MOVE  = 5'd23;
    localparam logic [4:0] ST_OUT   = 5'd24;

    // Configuration registers
    logic [30:0] r_max_vel, r_max_acc, r_min_vel;
    logic [15:0] r_step_time;

    // Profile state
    logic [4:0]         r_state, n_state;
    logic               r_issued, n_issued;
    logic               r_run, n_run;
    logic signed [31:0] r_goal, n_goal;
    logic signed [31:0] r_trav, n_trav;
    logic signed [31:0] r_pk, n_pk;
    logic signed [31:0] r_ct, n_ct;
    logic signed [31:0] r_ft, n_ft;
    logic signed [31:0] r_rea, n_rea;
    logic signed [31:0] r_cea, n_cea;

    // Scratch
    logic signed [31:0] r_rise, n_rise;
    logic signed [31:0] r_v0a, n_v0a;
    logic signed [31:0] r_da, n_da;
    logic signed [31:0] r_sq, n_sq;
    logic signed [31:0] r_s0, n_s0;
    logic signed [31:0] r_b, n_b;
    logic signed [31:0] r_vel, n_vel;
    logic signed [31:0] r_acc, n_acc;
    logic signed [63:0] r_w0, n_w0;
    logic signed [63:0] r_w1, n_w1;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_o_angle, n_o_angle;
    logic signed [31:0] r_o_vel, n_o_vel;
    logic signed [31:0] r_o_acc, n_o_acc;
    logic               r_o_last, n_o_last;

    // Shared unit
    t_alu_req           w_req;
    t_alu_rsp           w_rsp;
    logic [1:0]         w_op;
    logic signed [63:0] w_opa;
    logic signed [32:0] w_opb;
    logic signed [63:0] w_res;
    logic               w_is_op;
    logic               w_done;

    logic signed [31:0] w_acc, w_vm, w_v0;
    logic signed [31:0] w_q, w_r32;
    logic signed [32:0] w_pk_v0;
    logic signed [31:0] w_ct_ft, w_gx;
    logic signed [31:0] w_pk_sat, w_pk_new;
    logic signed [31:0] w_rad;
    logic signed [63:0] w_vel_sum;
    logic               w_in_xfer, w_cfg_wr;

    // A zero maximum velocity or acceleration acts as one LSB
    assign w_acc = (r_max_acc == '0) ? 32'sd1 : $signed({1'b0, r_max_acc});
    assign w_vm  = (r_max_vel == '0) ? 32'sd1 : $signed({1'b0, r_max_vel});
    assign w_v0  = $signed({1'b0, r_min_vel});

    assign w_q     = f_qscale(w_res);
    assign w_r32   = w_res[31:0];
    assign w_pk_v0 = 33'(r_pk) - 33'(w_v0);
    assign w_ct_ft = f_sat32(64'(r_ct) - 64'(r_ft));
    assign w_gx    = f_sat32(64'(r_goal) - 64'(r_trav));

    // Peak: base less the distance-band offset, capped to vmax, floored at one LSB
    assign w_pk_sat = f_sat32(64'(r_s0) - 64'(f_offset(r_goal)));
    always_comb begin
        w_pk_new = w_pk_sat;
        if (w_pk_sat > w_vm) begin
            w_pk_new = w_vm;
        end
        if (w_pk_new < 32'sd1) begin
            w_pk_new = 32'sd1;
        end
    end

    // Radicand: saturated, negative taken as zero
    always_comb begin
        w_rad = f_sat32(64'(r_s0) + (64'(w_q) <<< 3));
        if (w_rad[31]) begin
            w_rad = '0;
        end
    end

    assign w_vel_sum = 64'(r_b) + w_res;

    // Operand selection for the shared unit
    always_comb begin
        w_is_op = 1'b1;
        w_op = OP_MUL;
        w_opa = '0;
        w_opb = '0;
        case (r_state)
            ST_DA: begin
                w_opa = 64'(r_goal);
                w_opb = 33'(w_acc);
            end
            ST_VV, ST_U1: begin
                w_opa = 64'(w_v0);
                w_opb = 33'(w_v0);
            end
            ST_BASE: begin
                w_op = OP_DIV;
                w_opa = r_w0;
                w_opb = $signed({w_vm, 1'b0});
            end
            ST_RISE: begin
                w_op = OP_DIV;
                w_opa = 64'(w_pk_v0) <<< FRAC_BITS;
                w_opb = 33'(w_acc);
            end
            ST_V0A: begin
                w_op = OP_DIV;
                w_opa = 64'(w_v0) <<< FRAC_BITS;
                w_opb = 33'(w_acc);
            end
            ST_DAD: begin
                w_op = OP_DIV;
                w_opa = 64'(r_goal) <<< FRAC_BITS;
                w_opb = 33'(r_pk);
            end
            ST_SQ1: begin
                w_op = OP_DIV;
                w_opa = r_w1;
                w_opb = 33'(w_acc);
            end
            ST_SQ2: begin
                w_op = OP_DIV;
                w_opa = 64'(r_s0) <<< FRAC_BITS;
                w_opb = 33'(r_pk);
            end
            ST_PKA: begin
                w_op = OP_DIV;
                w_opa = 64'(r_pk) <<< FRAC_BITS;
                w_opb = 33'(w_acc);
            end
            ST_M1: begin
                w_opa = 64'(w_acc);
                w_opb = 33'(r_rise);
            end
            ST_M2: begin
                w_opa = 64'(r_s0);
                w_opb = 33'(r_rise);
            end
            ST_M3: begin
                w_opa = 64'(w_v0);
                w_opb = 33'(r_rise);
            end
            ST_M4: begin
                w_opa = 64'(r_pk);
                w_opb = 33'(r_ct);
            end
            ST_M5: begin
                w_opa = 64'(r_pk);
                w_opb = 33'(r_rise);
            end
            ST_U2: begin
                w_opa = 64'(r_trav);
                w_opb = 33'(w_acc);
            end
            ST_D1: begin
                w_opa = 64'(w_acc);
                w_opb = 33'(w_ct_ft);
            end
            ST_D2: begin
                w_opa = 64'(r_b);
                w_opb = 33'(r_b);
            end
            ST_D3: begin
                w_opa = 64'(w_acc);
                w_opb = 33'(w_gx);
            end
            ST_ROOT: begin
                w_op = OP_SQRT;
                w_opa = 64'(r_s0);
            end
            ST_MOVE: begin
                w_opa = 64'(r_vel);
                w_opb = $signed({17'b0, r_step_time});
            end
            default: begin
                w_is_op = 1'b0;
            end
        endcase
    end

    assign w_req.op    = w_op;
    assign w_req.start = w_is_op && !r_issued && !w_rsp.busy;
    assign w_done      = w_is_op && r_issued && w_rsp.done;

    atp_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_op_a   (w_opa),
        .i_op_b   (w_opb),
        .o_rsp    (w_rsp),
        .o_result (w_res)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_issued = r_issued;
        n_run = r_run;
        n_goal = r_goal;
        n_trav = r_trav;
        n_pk = r_pk;
        n_ct = r_ct;
        n_ft = r_ft;
        n_rea = r_rea;
        n_cea = r_cea;
        n_rise = r_rise;
        n_v0a = r_v0a;
        n_da = r_da;
        n_sq = r_sq;
        n_s0 = r_s0;
        n_b = r_b;
        n_vel = r_vel;
        n_acc = r_acc;
        n_w0 = r_w0;
        n_w1 = r_w1;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_angle = r_o_angle;
        n_o_vel = r_o_vel;
        n_o_acc = r_o_acc;
        n_o_last = r_o_last;

        if (w_req.start) begin
            n_issued = 1'b1;
        end
        if (w_done) begin
            n_issued = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (!i_action) begin
                        // plan a new turn
                        n_goal = i_target_angle;
                        n_trav = '0;
                        n_run = 1'b0;
                        n_state = ST_DA;
                    end else if (r_run) begin
                        if (r_trav < r_rea) begin
                            n_b = w_v0;
                            n_acc = w_acc;
                            n_state = ST_U1;
                        end else if (r_trav < r_cea) begin
                            n_vel = r_pk;
                            n_acc = '0;
                            n_state = ST_MOVE;
                        end else begin
                            n_acc = -w_acc;
                            n_state = ST_D1;
                        end
                    end
                end
            end
            ST_DA: if (w_done) begin
                n_w0 = w_res;
                n_state = ST_VV;
            end
            ST_VV: if (w_done) begin
                n_w1 = w_res;
                n_w0 = r_w0 + w_res;
                n_state = ST_BASE;
            end
            ST_BASE: if (w_done) begin
                n_s0 = f_sat32(64'(w_r32) + 64'(w_vm >>> 1));
                n_state = ST_PEAK;
            end
            ST_PEAK: begin
                n_pk = w_pk_new;
                n_state = ST_RISE;
            end
            ST_RISE: if (w_done) begin
                n_rise = w_r32;
                n_state = ST_V0A;
            end
            ST_V0A: if (w_done) begin
                n_v0a = w_r32;
                n_state = ST_DAD;
            end
            ST_DAD: if (w_done) begin
                n_da = w_r32;
                n_state = ST_SQ1;
            end
            ST_SQ1: if (w_done) begin
                n_s0 = w_r32;
                n_state = ST_SQ2;
            end
            ST_SQ2: if (w_done) begin
                n_sq = w_r32;
                n_state = ST_PKA;
            end
            ST_PKA: if (w_done) begin
                n_s0 = w_r32;
                n_state = ST_TIMES;
            end
            ST_TIMES: begin
                n_ct = f_sat32(64'(r_da) - 64'(r_v0a) + 64'(r_sq));
                n_ft = f_sat32(64'(r_da) + 64'(r_s0) - (64'(r_v0a) <<< 1) + 64'(r_sq));
                n_state = ST_M1;
            end
            ST_M1: if (w_done) begin
                n_s0 = w_q;
                n_state = ST_M2;
            end
            ST_M2: if (w_done) begin
                n_s0 = w_q;
                n_state = ST_M3;
            end
            ST_M3: if (w_done) begin
                n_rea = f_sat32(f_half(64'(r_s0)) + 64'(w_q));
                n_state = ST_M4;
            end
            ST_M4: if (w_done) begin
                n_s0 = w_q;
                n_state = ST_M5;
            end
            ST_M5: if (w_done) begin
                n_cea = f_sat32(64'(r_rea) + 64'(r_s0) - 64'(w_q));
                n_run = !r_goal[31];
                n_state = ST_IDLE;
            end
            ST_U1: if (w_done) begin
                n_s0 = w_q;
                n_state = ST_U2;
            end
            ST_U2, ST_D3: if (w_done) begin
                n_s0 = w_rad;
                n_state = ST_ROOT;
            end
            ST_D1: if (w_done) begin
                n_b = f_sat32(64'(r_pk) + 64'(w_q));
                n_state = ST_D2;
            end
            ST_D2: if (w_done) begin
                n_s0 = w_q;
                n_state = ST_D3;
            end
            ST_ROOT: if (w_done) begin
                n_vel = f_sat32(f_half(w_vel_sum));
                n_state = ST_MOVE;
            end
            ST_MOVE: if (w_done) begin
                n_s0 = f_sat32(64'(r_trav) + 64'(w_q));
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_angle = r_trav;
                    n_o_vel = r_vel;
                    n_o_acc = r_acc;
                    n_o_last = (r_s0 > r_goal);
                    n_trav = r_s0;
                    if (r_s0 > r_goal) begin
                        n_run = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_issued <= 1'b0;
            r_run <= 1'b0;
            r_out_valid <= 1'b0;
            r_goal <= '0;
            r_trav <= '0;
            r_pk <= '0;
            r_ct <= '0;
            r_ft <= '0;
            r_rea <= '0;
            r_cea <= '0;
        end else begin
            r_state <= n_state;
            r_issued <= n_issued;
            r_run <= n_run;
            r_out_valid <= n_out_valid;
            r_goal <= n_goal;
            r_trav <= n_trav;
            r_pk <= n_pk;
            r_ct <= n_ct;
            r_ft <= n_ft;
            r_rea <= n_rea;
            r_cea <= n_cea;
        end
    end

    // Scratch and output payload: no reset
    always_ff @(posedge i_clk) begin
        r_rise <= n_rise;
        r_v0a <= n_v0a;
        r_da <= n_da;
        r_sq <= n_sq;
        r_s0 <= n_s0;
        r_b <= n_b;
        r_vel <= n_vel;
        r_acc <= n_acc;
        r_w0 <= n_w0;
        r_w1 <= n_w1;
        r_o_angle <= n_o_angle;
        r_o_vel <= n_o_vel;
        r_o_acc <= n_o_acc;
        r_o_last <= n_o_last;
    end

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vel <= 31'd65536;
            r_max_acc <= 31'd65536;
            r_min_vel <= '0;
            r_step_time <= 16'd655;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_MAX_VEL:   r_max_vel <= pwdata[30:0];
                REG_MAX_ACC:   r_max_acc <= pwdata[30:0];
                REG_MIN_VEL:   r_min_vel <= pwdata[30:0];
                REG_STEP_TIME: r_step_time <= pwdata[15:0];
                default:       r_step_time <= r_step_time;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MAX_VEL:   prdata = {1'b0, r_max_vel};
            REG_MAX_ACC:   prdata = {1'b0, r_max_acc};
            REG_MIN_VEL:   prdata = {1'b0, r_min_vel};
            REG_STEP_TIME: prdata = {16'b0, r_step_time};
            default:       prdata = '0;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_angle_done   = r_o_angle;
    assign o_velocity     = r_o_vel;
    assign o_acceleration = r_o_acc;
    assign o_last_point   = r_o_last;

endmodule
